[src/scc_pkg.sv]
package scc_pkg;
  localparam int MAX_VERTS = 32;
  localparam int MAX_DEG   = 8;
  localparam int VW = 5;
  localparam int SW = 3;
  localparam int AW = VW + SW;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLR,
    ST_P1_SCAN,
    ST_TOP,
    ST_EDGE,
    ST_P2_POP,
    ST_P2_CHK,
    ST_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic         we;
    logic [AW-1:0] addr;
    logic [6:0]   wdata;
  } adj_wr_t;
endpackage

[src/scc_graph_mem.sv]
module scc_graph_mem import scc_pkg::*; (
  input  logic          clk,
  input  adj_wr_t       wr,
  input  logic [3:0]    deg_wdata,
  input  logic [AW-1:0] raddr,
  output logic [6:0]    adj_rdata,
  output logic [3:0]    deg_rdata
);
  logic [6:0] adj_mem [MAX_VERTS*MAX_DEG];
  logic [3:0] deg_mem [MAX_VERTS];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      adj_mem[wr.addr] <= wr.wdata;
      deg_mem[wr.addr[AW-1:SW]] <= deg_wdata;
    end
    adj_rdata <= adj_mem[raddr];
    deg_rdata <= deg_mem[raddr[AW-1:SW]];
  end
endmodule

[src/strongly_connected_components_core.sv]
// Kosaraju strongly connected components engine.
// Input channel (in_valid/in_stall): req_type 0 loads one adjacency entry
// (vertex, slot, signed neighbor, degree) into the graph memory, one
// transaction per cycle; req_type 1 starts a run. During a run in_stall
// stays high and the next transaction is taken once the run is back in idle.
// A run clears the visited marks, walks incoming
// edges to build the finish order, clears again and walks outgoing edges
// from the popped vertices. Every vertex is reported on the output channel
// (out_valid/out_stall) with its component number, the final one carrying
// out_last_of_run; each result is held back until the next one is known.
// In each pass every adjacency slot visited takes a graph memory read,
// issued from the state before, followed by the edge step.
// Receiver stall holds the result register; the walk goes on and waits
// only in the emit and done states until the result register is free.
// Reset (rst_n low, synchronous) returns to idle, empties both stacks and
// sets vertex_count to 1; graph contents are kept undefined until loaded.
module strongly_connected_components_core import scc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [5:0]        cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_req_type,
  input  logic [4:0]        in_vertex,
  input  logic [2:0]        in_slot,
  input  logic signed [6:0] in_neighbor,
  input  logic [3:0]        in_degree,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [4:0]        out_vertex_id,
  output logic [5:0]        out_component,
  output logic              out_last_of_run
);
  state_t state_r, state_nxt;
  logic [5:0] vcount_r;
  logic [5:0] n;
  logic pass2_r;
  logic [VW:0] scan_r;
  logic [VW:0] wdepth_r;
  logic [VW:0] ftop_r;
  logic [5:0] comp_r;
  logic [VW-1:0] cur_u_r;
  logic [SW:0] cur_i_r;
  logic [VW-1:0] start_r;

  logic [VW-1:0] wv_mem [MAX_VERTS];
  logic [SW:0]   ws_mem [MAX_VERTS];
  logic [VW-1:0] fs_mem [MAX_VERTS];
  logic          vis_mem [MAX_VERTS];

  logic [VW-1:0] nb_w;
  logic [VW-1:0] top_v;
  logic [SW:0]   top_s;

  logic [6:0] adj_rdata;
  logic [3:0] deg_rdata;
  logic [3:0] deg_c;
  adj_wr_t wr;
  logic [AW-1:0] raddr;
  logic [3:0] deg_in;
  logic accept;

  logic ov_r, last_r;
  logic [4:0] ovid_r;
  logic [5:0] ocomp_r;
  logic have_pend_r;
  logic [4:0] pvid_r;
  logic [5:0] pcomp_r;

  assign n = (vcount_r > 6'(MAX_VERTS)) ? 6'(MAX_VERTS) : vcount_r;
  assign in_stall = (state_r != ST_IDLE);
  assign accept = in_valid && !in_stall;
  assign deg_in = (in_degree > 4'(MAX_DEG)) ? 4'(MAX_DEG) : in_degree;
  assign wr.we = accept && !in_req_type;
  assign wr.addr = {in_vertex, in_slot};
  assign wr.wdata = in_neighbor;
  assign top_v = wv_mem[5'(wdepth_r - 1'b1)];
  assign top_s = ws_mem[5'(wdepth_r - 1'b1)];
  assign deg_c = (deg_rdata > 4'(MAX_DEG)) ? 4'(MAX_DEG) : deg_rdata;

  // address the slot that the edge step of the next cycle works on
  always_comb begin
    case (state_r)
      ST_TOP:    raddr = {top_v, top_s[SW-1:0]};
      ST_P2_CHK: raddr = {start_r, {SW{1'b0}}};
      default:   raddr = {cur_u_r, cur_i_r[SW-1:0]};
    endcase
  end

  scc_graph_mem u_mem (
    .clk(clk), .wr(wr), .deg_wdata(deg_in), .raddr(raddr),
    .adj_rdata(adj_rdata), .deg_rdata(deg_rdata)
  );

  // neighbor decode in the chosen direction
  logic signed [6:0] nb_s;
  logic nb_ok;
  always_comb begin
    nb_s = pass2_r ? $signed(adj_rdata) : -$signed(adj_rdata);
    nb_ok = (nb_s > 0) && (nb_s <= $signed({1'b0, n}));
    nb_w = 5'(nb_s - 7'sd1);
  end

  // result register: a pending entry is emitted as last only once the run ends
  logic out_free;
  assign out_free = !ov_r || !out_stall;
  logic ov_load;
  assign ov_load = out_free && have_pend_r &&
                   (state_r == ST_EMIT || state_r == ST_DONE);

  logic edge_in_range;
  assign edge_in_range = (cur_i_r < {1'b0, deg_c});

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (accept && in_req_type) state_nxt = ST_CLR;
      ST_CLR: begin
        if (n == 0) state_nxt = ST_DONE;
        else if (scan_r + 1'b1 >= {1'b0, n})
          state_nxt = pass2_r ? ST_P2_POP : ST_P1_SCAN;
      end
      ST_P1_SCAN: state_nxt = (scan_r >= {1'b0, n}) ? ST_CLR : ST_P2_CHK;
      ST_P2_POP:  state_nxt = (ftop_r == 0) ? ST_DONE : ST_P2_CHK;
      ST_P2_CHK: begin
        if (vis_mem[start_r]) state_nxt = pass2_r ? ST_P2_POP : ST_P1_SCAN;
        else state_nxt = ST_EDGE;
      end
      ST_TOP: begin
        if (wdepth_r == 0) state_nxt = pass2_r ? ST_P2_POP : ST_P1_SCAN;
        else state_nxt = ST_EDGE;
      end
      ST_EDGE: begin
        if (!edge_in_range && pass2_r) state_nxt = ST_EMIT;
        else state_nxt = ST_TOP;
      end
      ST_EMIT:    if (out_free) state_nxt = ST_TOP;
      ST_DONE:    if (out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath sequencing; graph memory read issued one state ahead
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      vcount_r <= 6'd1;
      pass2_r <= 1'b0;
      scan_r <= '0;
      wdepth_r <= '0;
      ftop_r <= '0;
      comp_r <= '0;
      ov_r <= 1'b0;
      have_pend_r <= 1'b0;
      last_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) vcount_r <= cfg_wdata;
      if (ov_load) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && in_req_type) begin
            pass2_r <= 1'b0;
            scan_r <= '0;
            ftop_r <= '0;
            comp_r <= '0;
            have_pend_r <= 1'b0;
          end
        end
        ST_CLR: begin
          vis_mem[scan_r[VW-1:0]] <= 1'b0;
          if (state_nxt != ST_CLR) scan_r <= '0;
          else scan_r <= scan_r + 1'b1;
        end
        ST_P1_SCAN: begin
          if (scan_r >= {1'b0, n}) begin
            pass2_r <= 1'b1;
            scan_r <= '0;
          end else begin
            start_r <= scan_r[VW-1:0];
            scan_r <= scan_r + 1'b1;
          end
        end
        ST_P2_POP: begin
          if (ftop_r != 0) begin
            start_r <= fs_mem[5'(ftop_r - 1'b1)];
            ftop_r <= ftop_r - 1'b1;
          end
        end
        ST_P2_CHK: begin
          // visited test of the start vertex
          if (!vis_mem[start_r]) begin
            vis_mem[start_r] <= 1'b1;
            if (pass2_r) comp_r <= comp_r + 1'b1;
            wv_mem[0] <= start_r;
            ws_mem[0] <= '0;
            cur_u_r <= start_r;
            cur_i_r <= '0;
            wdepth_r <= 6'd1;
          end
        end
        ST_TOP: begin
          if (wdepth_r != 0) begin
            cur_u_r <= top_v;
            cur_i_r <= top_s;
          end
        end
        ST_EDGE: begin
          if (edge_in_range) begin
            ws_mem[5'(wdepth_r - 1'b1)] <= cur_i_r + 1'b1;
            if (nb_ok && !vis_mem[nb_w]) begin
              vis_mem[nb_w] <= 1'b1;
              wv_mem[wdepth_r[VW-1:0]] <= nb_w;
              ws_mem[wdepth_r[VW-1:0]] <= '0;
              wdepth_r <= wdepth_r + 1'b1;
            end
          end else begin
            wdepth_r <= wdepth_r - 1'b1;
            if (!pass2_r) begin
              fs_mem[ftop_r[VW-1:0]] <= cur_u_r;
              ftop_r <= ftop_r + 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            if (have_pend_r) begin
              ovid_r <= pvid_r;
              ocomp_r <= pcomp_r;
              last_r <= 1'b0;
            end
            have_pend_r <= 1'b1;
            pvid_r <= cur_u_r;
            pcomp_r <= comp_r;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            if (have_pend_r) begin
              ovid_r <= pvid_r;
              ocomp_r <= pcomp_r;
              last_r <= 1'b1;
            end
            have_pend_r <= 1'b0;
            pass2_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = ov_r;
  assign out_vertex_id = ovid_r;
  assign out_component = ocomp_r;
  assign out_last_of_run = last_r;
endmodule
